[design/mi3_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi3_pkg
// Types, widths and cofactor tables shared by the 3x3 matrix inverse blocks.
// ----------------------------------------------------------------------------
package mi3_pkg;

	localparam int ELEM_WIDTH = 16;
	localparam int N_ELEM     = 9;
	localparam int PROD_W     = 2 * ELEM_WIDTH;
	localparam int COF_W      = PROD_W + 1;
	localparam int DET_W      = 3 * ELEM_WIDTH + 1;
	localparam int MAG_W      = PROD_W;
	localparam int DEN_W      = DET_W - 1;
	localparam int INV_W      = 32;
	localparam int FRAC_SHIFT = 24;
	localparam int IDX_W      = 4;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(N_ELEM - 1);

	localparam int MID_DEPTH_DEF = 2;
	localparam int OUT_DEPTH_DEF = 8;

	localparam logic [INV_W-1:0] POS_SAT = {1'b0, {(INV_W-1){1'b1}}};
	localparam logic [INV_W-1:0] NEG_SAT = {1'b1, {(INV_W-1){1'b0}}};

	// minor p*s - q*r for each adjugate entry, row-major
	localparam int COF_P [N_ELEM] = '{4, 1, 1, 3, 0, 0, 3, 0, 0};
	localparam int COF_Q [N_ELEM] = '{5, 2, 2, 5, 2, 2, 4, 1, 1};
	localparam int COF_R [N_ELEM] = '{7, 7, 4, 6, 6, 3, 6, 6, 3};
	localparam int COF_S [N_ELEM] = '{8, 8, 5, 8, 8, 5, 7, 7, 4};

	typedef logic signed [ELEM_WIDTH-1:0] elem_t;
	typedef logic [N_ELEM-1:0][ELEM_WIDTH-1:0] mat_t;

	typedef struct packed {
		logic [N_ELEM-1:0][COF_W-1:0] adj;
		logic [DET_W-1:0]             det;
	} mid_t;

	typedef struct packed {
		logic [N_ELEM-1:0][INV_W-1:0] inv;
		logic                         singular;
		logic [DET_W-1:0]             det;
	} res_t;

	typedef struct packed {
		logic [MAG_W-1:0] num;
		logic [DEN_W-1:0] den;
		logic             neg;
		logic             det_neg;
		logic [IDX_W-1:0] idx;
	} div_req_t;

	typedef struct packed {
		logic [INV_W-1:0] quo;
		logic [DEN_W-1:0] den;
		logic             det_neg;
		logic [IDX_W-1:0] idx;
	} div_rsp_t;

endpackage

[design/mi3_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi3_fifo
// Small register queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module mi3_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  logic [WIDTH-1:0] din,
	input  logic             pop,
	output logic             empty,
	output logic [WIDTH-1:0] dout
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push, do_pop;

	assign full    = cnt_q == CNT_W'(DEPTH);
	assign empty   = cnt_q == '0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= din;
		end
	end

endmodule

[design/mi3_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi3_front
// Stalling pipeline: cofactors, adjugate and determinant of one matrix.
// ----------------------------------------------------------------------------
module mi3_front import mi3_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	output logic full,
	input  mat_t mat,
	output logic out_valid,
	input  logic out_ready,
	output mid_t out_data
);

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic adv1, adv2, adv3, adv4, adv5;

	elem_t                    m_s1   [N_ELEM];
	logic signed [PROD_W-1:0] ps_s2  [N_ELEM];
	logic signed [PROD_W-1:0] qr_s2  [N_ELEM];
	elem_t                    row_s2 [3];
	logic signed [COF_W-1:0]  adj_s3 [N_ELEM];
	elem_t                    row_s3 [3];
	logic signed [DET_W-1:0]  dp_s4  [3];
	logic signed [COF_W-1:0]  adj_s4 [N_ELEM];
	logic signed [DET_W-1:0]  det_s5;
	logic signed [COF_W-1:0]  adj_s5 [N_ELEM];

	assign adv5 = !v_s5 || out_ready;
	assign adv4 = !v_s4 || adv5;
	assign adv3 = !v_s3 || adv4;
	assign adv2 = !v_s2 || adv3;
	assign adv1 = !v_s1 || adv2;
	assign full = !adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= push;
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
			if (adv4) v_s4 <= v_s3;
			if (adv5) v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		logic signed [COF_W-1:0] diff;
		for (int k = 0; k < N_ELEM; k++) begin
			if (adv1) m_s1[k] <= elem_t'(mat[k]);
			if (adv2) begin
				ps_s2[k] <= m_s1[COF_P[k]] * m_s1[COF_S[k]];
				qr_s2[k] <= m_s1[COF_Q[k]] * m_s1[COF_R[k]];
			end
			if (adv3) begin
				diff = COF_W'(ps_s2[k]) - COF_W'(qr_s2[k]);
				// odd positions carry the negative cofactor sign
				adj_s3[k] <= (k % 2 == 1) ? -diff : diff;
			end
			if (adv4) adj_s4[k] <= adj_s3[k];
			if (adv5) adj_s5[k] <= adj_s4[k];
		end
		for (int j = 0; j < 3; j++) begin
			if (adv2) row_s2[j] <= m_s1[j];
			if (adv3) row_s3[j] <= row_s2[j];
			// first row against adjugate column 0
			if (adv4) dp_s4[j] <= DET_W'(row_s3[j]) * DET_W'(adj_s3[3 * j]);
		end
		if (adv5) det_s5 <= dp_s4[0] + dp_s4[1] + dp_s4[2];
	end

	assign out_valid = v_s5;

	always_comb begin
		for (int k = 0; k < N_ELEM; k++) begin
			out_data.adj[k] = adj_s5[k];
		end
		out_data.det = det_s5;
	end

endmodule

[design/mi3_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi3_div
// Pipelined restoring divider, one quotient bit per stage, with saturation.
// ----------------------------------------------------------------------------
module mi3_div import mi3_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  div_req_t in_req,
	output logic     out_valid,
	output div_rsp_t out_rsp
);

	localparam int N_W = MAG_W + FRAC_SHIFT;

	logic             v_q    [INV_W+1];
	logic [DEN_W-1:0] rem_q  [INV_W+1];
	logic [INV_W-1:0] rest_q [INV_W+1];
	logic [INV_W-1:0] quo_q  [INV_W+1];
	logic             ovf_q  [INV_W+1];
	logic             neg_q  [INV_W+1];
	logic [DEN_W-1:0] den_q  [INV_W+1];
	logic             dneg_q [INV_W+1];
	logic [IDX_W-1:0] idx_q  [INV_W+1];

	logic [N_W-1:0]     n_full;
	logic [N_W-INV_W-1:0] n_top;
	logic [DEN_W:0]     t_c  [INV_W];
	logic               ge_c [INV_W];
	logic [INV_W-1:0]   q_fin, q_sat;
	logic               ovr_vld;
	div_rsp_t           rsp_q;

	assign n_full = {in_req.num, FRAC_SHIFT'(0)};
	assign n_top  = n_full[N_W-1:INV_W];

	always_comb begin
		for (int k = 0; k < INV_W; k++) begin
			t_c[k]  = {rem_q[k], rest_q[k][INV_W-1]};
			ge_c[k] = t_c[k] >= {1'b0, den_q[k]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= INV_W; k++) v_q[k] <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			v_q[0] <= in_valid;
			for (int k = 0; k < INV_W; k++) v_q[k+1] <= v_q[k];
			out_valid <= v_q[INV_W];
		end
	end

	always_ff @(posedge clk) begin
		rem_q[0]  <= DEN_W'(n_top);
		rest_q[0] <= n_full[INV_W-1:0];
		quo_q[0]  <= '0;
		// quotient of 2^32 or more saturates either way
		ovf_q[0]  <= DEN_W'(n_top) >= in_req.den;
		neg_q[0]  <= in_req.neg;
		den_q[0]  <= in_req.den;
		dneg_q[0] <= in_req.det_neg;
		idx_q[0]  <= in_req.idx;
		for (int k = 0; k < INV_W; k++) begin
			rem_q[k+1]  <= ge_c[k] ? DEN_W'(t_c[k] - {1'b0, den_q[k]}) : t_c[k][DEN_W-1:0];
			rest_q[k+1] <= {rest_q[k][INV_W-2:0], 1'b0};
			quo_q[k+1]  <= {quo_q[k][INV_W-2:0], ge_c[k]};
			ovf_q[k+1]  <= ovf_q[k];
			neg_q[k+1]  <= neg_q[k];
			den_q[k+1]  <= den_q[k];
			dneg_q[k+1] <= dneg_q[k];
			idx_q[k+1]  <= idx_q[k];
		end
		rsp_q.quo     <= q_sat;
		rsp_q.den     <= den_q[INV_W];
		rsp_q.det_neg <= dneg_q[INV_W];
		rsp_q.idx     <= idx_q[INV_W];
	end

	assign q_fin = quo_q[INV_W];

	always_comb begin
		if (neg_q[INV_W]) begin
			ovr_vld = ovf_q[INV_W] || (q_fin > NEG_SAT);
			q_sat   = ovr_vld ? NEG_SAT : -q_fin;
		end else begin
			ovr_vld = ovf_q[INV_W] || q_fin[INV_W-1];
			q_sat   = ovr_vld ? POS_SAT : q_fin;
		end
		// singular matrix gives an all-zero inverse
		if (den_q[INV_W] == '0) begin
			q_sat = '0;
		end
	end

	assign out_rsp = rsp_q;

endmodule

[design/mi3_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi3_back
// Feeds nine adjugate entries per matrix to the shared divider and collects
// the quotients into one result word.
// ----------------------------------------------------------------------------
module mi3_back import mi3_pkg::*; #(
	parameter int OUT_DEPTH = OUT_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic mid_empty,
	input  mid_t mid_data,
	output logic mid_pop,
	output logic res_push,
	output res_t res_data,
	input  logic res_taken
);

	localparam int CNT_W = $clog2(OUT_DEPTH + 1);

	logic [IDX_W-1:0]        idx_q;
	logic [CNT_W-1:0]        cnt_q;
	logic                    issue, last, start;
	logic signed [COF_W-1:0] adj_sel;
	logic signed [DET_W-1:0] det_sel;
	logic [DET_W-1:0]        det_mag;
	div_req_t                req;
	logic                    rsp_valid;
	div_rsp_t                rsp;
	logic [INV_W-1:0]        inv_q [N_ELEM-1];

	// a matrix starts only when its result word has a reserved slot
	assign start   = (idx_q == '0) && (cnt_q < CNT_W'(OUT_DEPTH));
	assign issue   = !mid_empty && ((idx_q != '0) || start);
	assign last    = idx_q == LAST_IDX;
	assign mid_pop = issue && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			cnt_q <= '0;
		end else begin
			if (issue) begin
				idx_q <= last ? '0 : idx_q + 1'b1;
			end
			if ((issue && start) && !res_taken) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!(issue && start) && res_taken) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	assign adj_sel = mid_data.adj[idx_q];
	assign det_sel = mid_data.det;
	assign det_mag = det_sel[DET_W-1] ? -det_sel : det_sel;

	always_comb begin
		req.num     = adj_sel[COF_W-1] ? MAG_W'(-adj_sel) : MAG_W'(adj_sel);
		req.den     = det_mag[DEN_W-1:0];
		req.neg     = adj_sel[COF_W-1] ^ det_sel[DET_W-1];
		req.det_neg = det_sel[DET_W-1];
		req.idx     = idx_q;
	end

	mi3_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (issue),
		.in_req    (req),
		.out_valid (rsp_valid),
		.out_rsp   (rsp)
	);

	always_ff @(posedge clk) begin
		if (rsp_valid && (rsp.idx != LAST_IDX)) begin
			inv_q[rsp.idx[$clog2(N_ELEM-1)-1:0]] <= rsp.quo;
		end
	end

	assign res_push = rsp_valid && (rsp.idx == LAST_IDX);

	always_comb begin
		for (int k = 0; k < N_ELEM - 1; k++) begin
			res_data.inv[k] = inv_q[k];
		end
		res_data.inv[N_ELEM-1] = rsp.quo;
		res_data.singular      = rsp.den == '0;
		res_data.det = rsp.det_neg ? -{1'b0, rsp.den} : {1'b0, rsp.den};
	end

endmodule

[design/matrix_inverse_3x3.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_inverse_3x3
// 3x3 matrix inverse by adjugate over determinant, Q8.8 in, Q16.16 out.
// ----------------------------------------------------------------------------
// Input side is a queue: drive the nine Q8.8 elements with push; a word is
// taken on a clock edge with push high and full low.
// Result side is a queue: while empty is low the oldest result (nine Q16.16
// inverse entries, singular flag, determinant scaled by 2^-24) is on the
// ports, and it leaves on an edge with pop high.
// The nine entries of each matrix share one divider that takes one entry per
// cycle; the front pipeline takes a word per cycle until its small hand-off
// queue fills.
// From the accepting edge to empty going low a matrix passes the 5-stage
// cofactor and determinant pipeline, the hand-off queue, the issue of its
// nine entries, the 34-stage divider and the output queue.
// A singular matrix returns singular high, zero inverse and zero determinant.
// Reset clears all queues and pipelines; no result is pending afterwards.
// When the receiver stops popping, results wait in the output queue, the
// divider stops starting new matrices and full eventually rises.
// ----------------------------------------------------------------------------
module matrix_inverse_3x3 import mi3_pkg::*; #(
	parameter int MID_DEPTH = MID_DEPTH_DEF,
	parameter int OUT_DEPTH = OUT_DEPTH_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	output logic                    full,
	input  logic signed [15:0]      a_r0c0,
	input  logic signed [15:0]      a_r0c1,
	input  logic signed [15:0]      a_r0c2,
	input  logic signed [15:0]      a_r1c0,
	input  logic signed [15:0]      a_r1c1,
	input  logic signed [15:0]      a_r1c2,
	input  logic signed [15:0]      a_r2c0,
	input  logic signed [15:0]      a_r2c1,
	input  logic signed [15:0]      a_r2c2,
	output logic                    empty,
	input  logic                    pop,
	output logic signed [31:0]      inv_r0c0,
	output logic signed [31:0]      inv_r0c1,
	output logic signed [31:0]      inv_r0c2,
	output logic signed [31:0]      inv_r1c0,
	output logic signed [31:0]      inv_r1c1,
	output logic signed [31:0]      inv_r1c2,
	output logic signed [31:0]      inv_r2c0,
	output logic signed [31:0]      inv_r2c1,
	output logic signed [31:0]      inv_r2c2,
	output logic                    singular,
	output logic signed [48:0]      determinant
);

	mat_t mat;
	logic front_valid, mid_full, mid_empty, mid_pop;
	mid_t front_data, mid_data;
	logic res_push, res_full, res_taken;
	res_t res_in, res_out;

	assign mat = {a_r2c2, a_r2c1, a_r2c0, a_r1c2, a_r1c1, a_r1c0,
		a_r0c2, a_r0c1, a_r0c0};

	mi3_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.mat       (mat),
		.out_valid (front_valid),
		.out_ready (!mid_full),
		.out_data  (front_data)
	);

	mi3_fifo #(.WIDTH($bits(mid_t)), .DEPTH(MID_DEPTH)) u_mid_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (front_valid),
		.full   (mid_full),
		.din    (front_data),
		.pop    (mid_pop),
		.empty  (mid_empty),
		.dout   (mid_data)
	);

	mi3_back #(.OUT_DEPTH(OUT_DEPTH)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.mid_empty (mid_empty),
		.mid_data  (mid_data),
		.mid_pop   (mid_pop),
		.res_push  (res_push),
		.res_data  (res_in),
		.res_taken (res_taken)
	);

	mi3_fifo #(.WIDTH($bits(res_t)), .DEPTH(OUT_DEPTH)) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.full   (res_full),
		.din    (res_in),
		.pop    (pop),
		.empty  (empty),
		.dout   (res_out)
	);

	assign res_taken   = pop && !empty;
	assign inv_r0c0    = res_out.inv[0];
	assign inv_r0c1    = res_out.inv[1];
	assign inv_r0c2    = res_out.inv[2];
	assign inv_r1c0    = res_out.inv[3];
	assign inv_r1c1    = res_out.inv[4];
	assign inv_r1c2    = res_out.inv[5];
	assign inv_r2c0    = res_out.inv[6];
	assign inv_r2c1    = res_out.inv[7];
	assign inv_r2c2    = res_out.inv[8];
	assign singular    = res_out.singular;
	assign determinant = res_out.det;

`ifndef SYNTHESIS
	a_res_slot: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full)
		else $error("result word with no free slot");

	a_mid_pop: assert property (@(posedge clk) disable iff (!arst_n)
		mid_pop |-> !mid_empty)
		else $error("hand-off queue popped while empty");

	a_singular: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && singular) |-> (determinant == 0 && inv_r0c0 == 0 && inv_r2c2 == 0))
		else $error("singular result carries nonzero data");
`endif

endmodule
